### sv/gpmi_pkg.sv
// ----------------------------------------------------------------------------
// gpmi_pkg
// Shared types and constants of the GF(2) polynomial modular inverse unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpmi_pkg;

   // Width of the element, modulus and inverse ports
   localparam int ELEMENT_BITS = 16;

   // Modulus register value after reset: x^8 + x^4 + x^3 + x^2 + 1
   localparam logic [ELEMENT_BITS-1:0] MODULUS_RESET = 16'h011D;

   // What one pipeline stage does
   typedef enum logic {
      MODE_EUCLID,
      MODE_DIVIDE
   } gpmi_mode_type;

endpackage

`default_nettype wire

### sv/gpmi_stage.sv
// ----------------------------------------------------------------------------
// gpmi_stage
// One registered reduction step. Euclid mode reduces g by a shifted copy of
// a, updates the cofactor the same way and swaps the pair once deg(g) drops
// below deg(a). Divide mode reduces g by a and records the quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gpmi_stage import gpmi_pkg::*; #(
   parameter int            POLY_BITS = 16,
   parameter gpmi_mode_type MODE      = MODE_EUCLID
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    enable,
   input  wire                    in_valid,
   input  wire  [POLY_BITS-1:0]   in_g,
   input  wire  [POLY_BITS-1:0]   in_a,
   input  wire  [POLY_BITS-1:0]   in_cg,
   input  wire  [POLY_BITS-1:0]   in_ca,
   input  wire  [POLY_BITS-1:0]   in_n,
   output logic                   out_valid,
   output logic [POLY_BITS-1:0]   out_g,
   output logic [POLY_BITS-1:0]   out_a,
   output logic [POLY_BITS-1:0]   out_cg,
   output logic [POLY_BITS-1:0]   out_ca,
   output logic [POLY_BITS-1:0]   out_n
);

   localparam int LW = $clog2(POLY_BITS + 1);

   // Degree plus one, zero for the zero polynomial
   function automatic logic [LW-1:0] bit_len(input logic [POLY_BITS-1:0] v);
      logic [LW-1:0] n;
      n = '0;
      for (int i = 0; i < POLY_BITS; i++) begin
         if (v[i]) n = LW'(i + 1);
      end
      return n;
   endfunction

   logic [LW-1:0]        len_g;
   logic [LW-1:0]        len_a;
   logic [LW-1:0]        shift;
   logic                 do_reduce;
   logic [POLY_BITS-1:0] rem;
   logic                 valid_ff;
   logic [POLY_BITS-1:0] g_ff, g_in;
   logic [POLY_BITS-1:0] a_ff, a_in;
   logic [POLY_BITS-1:0] cg_ff, cg_in;
   logic [POLY_BITS-1:0] ca_ff, ca_in;
   logic [POLY_BITS-1:0] n_ff;

   // Reduce g by a aligned to its leading term
   always_comb begin
      len_g     = bit_len(in_g);
      len_a     = bit_len(in_a);
      shift     = len_g - len_a;
      do_reduce = (in_a != '0) && (len_g >= len_a);
      rem       = do_reduce ? (in_g ^ (in_a << shift)) : in_g;
   end

   generate
      if (MODE == MODE_EUCLID) begin : g_euclid
         logic [POLY_BITS-1:0] cof;
         logic                 do_swap;
         // Update the cofactor and swap once the remainder is done
         always_comb begin
            cof     = do_reduce ? (in_cg ^ (in_ca << shift)) : in_cg;
            do_swap = (in_a != '0) && (bit_len(rem) < len_a);
            g_in    = do_swap ? in_a : rem;
            a_in    = do_swap ? rem : in_a;
            cg_in   = do_swap ? in_ca : cof;
            ca_in   = do_swap ? cof : in_ca;
         end
      end else begin : g_divide
         // Set the quotient bit of this step
         always_comb begin
            g_in  = rem;
            a_in  = in_a;
            cg_in = do_reduce ? (in_cg | (POLY_BITS'(1) << shift)) : in_cg;
            ca_in = in_ca;
         end
      end
   endgenerate

   // Advance the stage when the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         g_ff  <= g_in;
         a_ff  <= a_in;
         cg_ff <= cg_in;
         ca_ff <= ca_in;
         n_ff  <= in_n;
      end
   end

   assign out_valid = valid_ff;
   assign out_g     = g_ff;
   assign out_a     = a_ff;
   assign out_cg    = cg_ff;
   assign out_ca    = ca_ff;
   assign out_n     = n_ff;

endmodule

`default_nettype wire

### sv/gf2_poly_modular_inverse_unit.sv
// ----------------------------------------------------------------------------
// gf2_poly_modular_inverse_unit
// Inverse of a binary polynomial modulo a programmable modulus polynomial,
// by the extended Euclidean algorithm in a linear pipeline.
//
//   channel  ports                            direction  width
//   req      req_valid/req_ready/req_element   in         16
//   rsp      rsp_valid/rsp_ready/rsp_inverse   out        16
//   csr      csr_write_en/csr_write_data       in         16
//
// The pipe runs 2*POLY_BITS+1 Euclid steps, then POLY_BITS steps each for
// the two closing divisions, each step registered.
// One transaction enters per cycle while no stalled result holds the output.
// Reset clears all stage valid bits and loads the modulus with 0x11D.
// A stalled result at the output freezes the whole pipe; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_poly_modular_inverse_unit import gpmi_pkg::*; #(
   parameter int POLY_BITS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [ELEMENT_BITS-1:0] req_element,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [ELEMENT_BITS-1:0] rsp_inverse,
   input  wire                     csr_write_en,
   input  wire  [ELEMENT_BITS-1:0] csr_write_data
);

   localparam int NEUC = 2 * POLY_BITS + 1;
   localparam int NDIV = POLY_BITS;
   localparam int NST  = NEUC + 2 * NDIV;

   logic [ELEMENT_BITS-1:0] modulus_ff;
   logic [POLY_BITS-1:0]    elem_w;
   logic [POLY_BITS-1:0]    mod_w;
   logic                    enable;

   logic                    st_valid [NST];
   logic [POLY_BITS-1:0]    st_g     [NST];
   logic [POLY_BITS-1:0]    st_a     [NST];
   logic [POLY_BITS-1:0]    st_cg    [NST];
   logic [POLY_BITS-1:0]    st_ca    [NST];
   logic [POLY_BITS-1:0]    st_n     [NST];

   // Hold the modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_write_en) begin
         modulus_ff <= csr_write_data;
      end
   end

   // Fit element and modulus to the working width
   always_comb begin
      elem_w = '0;
      mod_w  = '0;
      for (int i = 0; i < POLY_BITS; i++) begin
         if (i < ELEMENT_BITS) begin
            elem_w[i] = req_element[i];
            mod_w[i]  = modulus_ff[i];
         end
      end
   end

   // Stall every stage while the output holds an untaken result
   assign enable    = !st_valid[NST-1] || rsp_ready;
   assign req_ready = enable;

   generate
      for (genvar k = 0; k < NST; k++) begin : g_stage
         logic                 v_i;
         logic [POLY_BITS-1:0] g_i, a_i, cg_i, ca_i, n_i;

         if (k == 0) begin : g_entry
            // Start Euclid: g = n, a = element, cg = 0, ca = 1
            assign v_i  = req_valid;
            assign g_i  = mod_w;
            assign a_i  = elem_w;
            assign cg_i = '0;
            assign ca_i = POLY_BITS'(1);
            assign n_i  = mod_w;
         end else if (k == NEUC) begin : g_div1
            // First division: n / gcd, carry cg ^ n along
            assign v_i  = st_valid[k-1];
            assign g_i  = st_n[k-1];
            assign a_i  = st_g[k-1];
            assign cg_i = '0;
            assign ca_i = st_cg[k-1] ^ st_n[k-1];
            assign n_i  = st_n[k-1];
         end else if (k == NEUC + NDIV) begin : g_div2
            // Second division: (cg ^ n) mod quotient
            assign v_i  = st_valid[k-1];
            assign g_i  = st_ca[k-1];
            assign a_i  = st_cg[k-1];
            assign cg_i = '0;
            assign ca_i = '0;
            assign n_i  = st_n[k-1];
         end else begin : g_chain
            assign v_i  = st_valid[k-1];
            assign g_i  = st_g[k-1];
            assign a_i  = st_a[k-1];
            assign cg_i = st_cg[k-1];
            assign ca_i = st_ca[k-1];
            assign n_i  = st_n[k-1];
         end

         gpmi_stage #(
            .POLY_BITS (POLY_BITS),
            .MODE      ((k < NEUC) ? MODE_EUCLID : MODE_DIVIDE)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .enable    (enable),
            .in_valid  (v_i),
            .in_g      (g_i),
            .in_a      (a_i),
            .in_cg     (cg_i),
            .in_ca     (ca_i),
            .in_n      (n_i),
            .out_valid (st_valid[k]),
            .out_g     (st_g[k]),
            .out_a     (st_a[k]),
            .out_cg    (st_cg[k]),
            .out_ca    (st_ca[k]),
            .out_n     (st_n[k])
         );
      end
   endgenerate

   // Drive the result from the last remainder
   always_comb begin
      rsp_valid   = st_valid[NST-1];
      rsp_inverse = '0;
      for (int i = 0; i < ELEMENT_BITS; i++) begin
         if (i < POLY_BITS) rsp_inverse[i] = st_g[NST-1][i];
      end
   end

endmodule

`default_nettype wire

### sv/gpmi_checker.sv
// ----------------------------------------------------------------------------
// gpmi_checker
// Port-level checks on the inverse unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gpmi_checker import gpmi_pkg::*; (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_ready,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire [ELEMENT_BITS-1:0] rsp_inverse
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inverse))
      else $error("stalled result changed");

   // Drop the output valid after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Accept input exactly when the output can move
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

endmodule

bind gf2_poly_modular_inverse_unit gpmi_checker u_gpmi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_inverse (rsp_inverse)
);

`default_nettype wire
